// ===== rtl/ttd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttd_pkg: shared types for the typed task dispatcher
// Request/result payloads, status codes and controller/datapath links.
// ----------------------------------------------------------------------------
package ttd_pkg;

  localparam int NUM_UNITS         = 3;
  localparam int STACK_DEPTH_DEF   = 8;
  localparam int DURATION_BITS_DEF = 8;

  localparam logic KIND_ARRIVE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef enum logic [1:0] {
    ST_DISPATCH = 2'd0,
    ST_STACKED  = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_TICK     = 2'd3
  } ttd_status_e;

  typedef struct packed {
    logic       kind;
    logic [1:0] task_type;
    logic [7:0] duration;
  } ttd_req_t;

  typedef struct packed {
    ttd_status_e          status;
    logic [NUM_UNITS-1:0] busy_mask;
    logic [NUM_UNITS-1:0] finished_mask;
    logic [3:0]           stack_count;
    logic                 all_idle;
  } ttd_res_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture request
    logic arrive;  // apply arrival
    logic pop;     // move stack top into its unit
    logic count;   // count down units, close the tick
  } ttd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_tick;  // request on the input port is a tick
    logic can_pop;  // stack top valid and its unit free
  } ttd_sts_t;

endpackage
`default_nettype wire

// ===== rtl/typed_task_dispatcher_with_stack.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// typed_task_dispatcher_with_stack: three-unit task dispatcher, LIFO overflow
// Routes each task to the unit of its type, stacks or drops it when that unit
// is busy; each tick pops stack tops into free units, then counts units down.
// ----------------------------------------------------------------------------
//  port     dir  payload    handshake
//  start    in   req_i      accepted when start && !busy
//  busy     out  -          high while a request is in work
//  done_o   out  res_o      one-cycle strobe, receiver cannot stall
//
// Arrival: busy while in S_ARRIVE, result strobe the cycle after.
// Tick: busy through the pop loop and the countdown, with at most 3 stack pops
//   (one per unit), each pop waiting in S_POP_RD on the registered stack-top read.
// Reset (async, active low) frees all units and empties the stack.
// A new request may be accepted during the result strobe cycle.
// ----------------------------------------------------------------------------
module typed_task_dispatcher_with_stack #(
  parameter int STACK_DEPTH   = ttd_pkg::STACK_DEPTH_DEF,
  parameter int DURATION_BITS = ttd_pkg::DURATION_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire ttd_pkg::ttd_req_t req_i,
  output logic                   busy,
  output logic                   done_o,
  output ttd_pkg::ttd_res_t      res_o
);

  ttd_pkg::ttd_cmd_t cmd;
  ttd_pkg::ttd_sts_t sts;

  // sequencer: decides arrival vs. pop loop, issues datapath commands
  ttd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  // unit state, overflow stack and result register
  ttd_dpath #(
    .STACK_DEPTH   (STACK_DEPTH),
    .DURATION_BITS (DURATION_BITS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (res_o)
  );

  // accepted request always puts the block into work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // result strobe only once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  // a unit that finished on a tick cannot be reported busy
  a_fin_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((res_o.finished_mask & res_o.busy_mask) == '0))
    else $error("finished unit still flagged busy");

  // arrivals never finish units
  a_arrive_no_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status != ttd_pkg::ST_TICK)) |-> (res_o.finished_mask == '0))
    else $error("arrival result reports finished units");

  // all_idle implies nothing busy and nothing stacked
  a_all_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.all_idle) |-> (res_o.busy_mask == '0 && res_o.stack_count == '0))
    else $error("all_idle inconsistent with busy mask or stack count");

endmodule
`default_nettype wire

// ===== rtl/ttd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttd_ctrl: dispatcher sequencer
// Walks a request through arrival, or through the pop loop and countdown.
// ----------------------------------------------------------------------------
module ttd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire ttd_pkg::ttd_sts_t sts_i,
  output ttd_pkg::ttd_cmd_t      cmd_o,
  output logic                   busy_o,
  output logic                   done_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ARRIVE,
    S_POP_CHK,
    S_POP_RD
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= sts_i.in_tick ? S_POP_CHK : S_ARRIVE;
          end
        end
        S_ARRIVE: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        S_POP_CHK: begin
          if (sts_i.can_pop) begin
            state_q <= S_POP_RD;
          end else begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end
        S_POP_RD: begin
          state_q <= S_POP_CHK;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && start;
    cmd_o.arrive = (state_q == S_ARRIVE);
    cmd_o.pop    = (state_q == S_POP_CHK) && sts_i.can_pop;
    cmd_o.count  = (state_q == S_POP_CHK) && !sts_i.can_pop;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== rtl/ttd_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttd_dpath: dispatcher datapath
// Unit busy flags and countdowns, LIFO overflow stack, result register.
// ----------------------------------------------------------------------------
module ttd_dpath #(
  parameter int STACK_DEPTH   = ttd_pkg::STACK_DEPTH_DEF,
  parameter int DURATION_BITS = ttd_pkg::DURATION_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ttd_pkg::ttd_req_t req_i,
  input  wire ttd_pkg::ttd_cmd_t cmd_i,
  output ttd_pkg::ttd_sts_t      sts_o,
  output ttd_pkg::ttd_res_t      res_o
);

  localparam int NU      = ttd_pkg::NUM_UNITS;
  localparam int CntW    = $clog2(STACK_DEPTH + 1);
  localparam int AddrW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DurExtW = (DURATION_BITS > 8) ? DURATION_BITS : 8;

  ttd_pkg::ttd_req_t      req_q;
  logic [NU-1:0]          busy_q, busy_d;
  logic [DURATION_BITS-1:0] rem_q [NU];
  logic [DURATION_BITS-1:0] rem_d [NU];
  logic [CntW-1:0]        cnt_q, cnt_d;

  // overflow stack storage
  logic [1:0]               stk_type_mem [STACK_DEPTH];
  logic [DURATION_BITS-1:0] stk_dur_mem  [STACK_DEPTH];
  logic [1:0]               top_type_q;
  logic [DURATION_BITS-1:0] top_dur_q;
  logic [AddrW-1:0]         rd_addr, wr_addr;
  logic                     push;

  logic [DurExtW-1:0]       dur_ext;
  logic [DURATION_BITS-1:0] dur_trim;
  logic                     type_ok, unit_free, stk_full, top_free;
  logic [NU-1:0]            fin_d;
  ttd_pkg::ttd_status_e     status_d;
  ttd_pkg::ttd_res_t        res_q;

  assign dur_ext  = DurExtW'(req_q.duration);
  assign dur_trim = dur_ext[DURATION_BITS-1:0];
  assign type_ok  = (req_q.task_type < 2'(NU));
  assign stk_full = (cnt_q == CntW'(STACK_DEPTH));
  assign rd_addr  = (cnt_q == '0) ? '0 : AddrW'(cnt_q - 1'b1);
  assign wr_addr  = AddrW'(cnt_q);

  always_comb begin
    unit_free = 1'b0;
    top_free  = 1'b0;
    for (int i = 0; i < NU; i++) begin
      if (req_q.task_type == 2'(i)) unit_free = !busy_q[i];
      if (top_type_q == 2'(i))      top_free  = !busy_q[i];
    end
  end

  assign sts_o.in_tick = (req_i.kind == ttd_pkg::KIND_TICK);
  assign sts_o.can_pop = (cnt_q != '0) && top_free;

  always_comb begin
    busy_d   = busy_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    fin_d    = '0;
    push     = 1'b0;
    status_d = ttd_pkg::ST_TICK;
    if (cmd_i.arrive) begin
      priority if (!type_ok) begin
        status_d = ttd_pkg::ST_DROPPED;
      end else if (unit_free) begin
        status_d = ttd_pkg::ST_DISPATCH;
        for (int i = 0; i < NU; i++) begin
          if (req_q.task_type == 2'(i)) begin
            busy_d[i] = 1'b1;
            rem_d[i]  = dur_trim;
          end
        end
      end else if (!stk_full) begin
        status_d = ttd_pkg::ST_STACKED;
        push     = 1'b1;
        cnt_d    = cnt_q + 1'b1;
      end else begin
        status_d = ttd_pkg::ST_DROPPED;
      end
    end else if (cmd_i.pop) begin
      for (int i = 0; i < NU; i++) begin
        if (top_type_q == 2'(i)) begin
          busy_d[i] = 1'b1;
          rem_d[i]  = top_dur_q;
        end
      end
      cnt_d = cnt_q - 1'b1;
    end else if (cmd_i.count) begin
      for (int i = 0; i < NU; i++) begin
        if (busy_q[i]) begin
          if (rem_q[i] <= DURATION_BITS'(1)) begin
            rem_d[i]  = '0;
            busy_d[i] = 1'b0;
            fin_d[i]  = 1'b1;
          end else begin
            rem_d[i] = rem_q[i] - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      cnt_q  <= '0;
      for (int i = 0; i < NU; i++) rem_q[i] <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
    end
  end

  // stack memory: one write port, registered read of the top entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      stk_type_mem[wr_addr] <= req_q.task_type;
      stk_dur_mem[wr_addr]  <= dur_trim;
    end
    top_type_q <= stk_type_mem[rd_addr];
    top_dur_q  <= stk_dur_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.arrive || cmd_i.count) begin
      res_q.status        <= status_d;
      res_q.busy_mask     <= busy_d;
      res_q.finished_mask <= fin_d;
      res_q.stack_count   <= 4'(cnt_d);
      res_q.all_idle      <= (busy_d == '0) && (cnt_d == '0);
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire
